// ===== hw/rtl/ezr_pkg.sv =====
// Shared types, constants and helper functions for the Euler ZYX point rotator.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
package ezr_pkg;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int TRIG_STAGES_DEF = 16;
	localparam int ZW = 34;          // CORDIC datapath, Q2.30 with headroom
	localparam int TRIG_W = 32;      // sine and cosine, Q2.30
	localparam int MAT_W = 34;       // matrix entries, Q2.30
	localparam int ANG_SHIFT = 30 - (ANGLE_W - 3);
	localparam int unsigned Q_HALF = 32'd536870912;

	localparam logic signed [ZW-1:0] HALF_PI = 34'sh0_6487_ED51;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sh0_C90F_DAA2;
	localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

	typedef struct packed {
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
		logic signed [ANGLE_W-1:0] roll_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic signed [ANGLE_W-1:0] yaw_angle;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
	} out_t;

	typedef struct packed {
		logic signed [ZW-1:0] x;
		logic signed [ZW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [MAT_W-1:0] mat_e_t;

	// rot[0] roll, rot[1] pitch, rot[2] yaw
	typedef struct packed {
		rot_t [2:0] rot;
		logic [2:0] flip;
		coord_t [2:0] p;
	} cell_t;

	typedef struct packed {
		mat_e_t [8:0] r;
		coord_t [2:0] p;
	} mat_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = 34'sh0_3243_F6A8;
			1: a = 34'sh0_1DAC_6705;
			2: a = 34'sh0_0FAD_BAFC;
			3: a = 34'sh0_07F5_6EA6;
			4: a = 34'sh0_03FE_AB76;
			5: a = 34'sh0_01FF_D55B;
			6: a = 34'sh0_00FF_FAAA;
			7: a = 34'sh0_007F_FF55;
			8: a = 34'sh0_003F_FFEA;
			9: a = 34'sh0_001F_FFFD;
			10: a = 34'sh0_000F_FFFF;
			11: a = 34'sh0_0007_FFFF;
			12: a = 34'sh0_0003_FFFF;
			13: a = 34'sh0_0001_FFFF;
			14: a = 34'sh0_0000_FFFF;
			15: a = 34'sh0_0000_7FFF;
			16: a = 34'sh0_0000_3FFF;
			17: a = 34'sh0_0000_1FFF;
			18: a = 34'sh0_0000_0FFF;
			19: a = 34'sh0_0000_07FF;
			20: a = 34'sh0_0000_03FF;
			21: a = 34'sh0_0000_01FF;
			22: a = 34'sh0_0000_00FF;
			23: a = 34'sh0_0000_007F;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Q2.30 product, rounded half up
	function automatic logic signed [TRIG_W-1:0] qmul(input logic signed [TRIG_W-1:0] a,
			input logic signed [TRIG_W-1:0] b);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b;
		p = p + (2*TRIG_W)'(Q_HALF);
		return TRIG_W'(p >>> 30);
	endfunction

endpackage

// ===== hw/rtl/ezr_cell.sv =====
// One CORDIC rotation step for all three angles, with the point carried along.
// Depends on ezr_pkg.
`timescale 1ns / 1ps
module ezr_cell
	import ezr_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_rdy,
	input  cell_t up,
	output logic  dn_valid,
	input  logic  dn_rdy,
	output cell_t dn
);

	cell_t nxt;
	logic  v_q;
	cell_t d_q;
	logic  ld;

	always_comb begin
		nxt = up;
		for (int k = 0; k < 3; k++) begin
			if (!up.rot[k].z[ZW-1]) begin
				nxt.rot[k].x = $signed(up.rot[k].x) - ($signed(up.rot[k].y) >>> STAGE);
				nxt.rot[k].y = $signed(up.rot[k].y) + ($signed(up.rot[k].x) >>> STAGE);
				nxt.rot[k].z = $signed(up.rot[k].z) - atan_q30(STAGE);
			end else begin
				nxt.rot[k].x = $signed(up.rot[k].x) + ($signed(up.rot[k].y) >>> STAGE);
				nxt.rot[k].y = $signed(up.rot[k].y) - ($signed(up.rot[k].x) >>> STAGE);
				nxt.rot[k].z = $signed(up.rot[k].z) + atan_q30(STAGE);
			end
		end
	end

	assign ld = !v_q || dn_rdy;
	assign up_rdy = ld;
	assign dn_valid = v_q;
	assign dn = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ld) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && up_valid) begin
			d_q <= nxt;
		end
	end

endmodule

// ===== hw/rtl/ezr_matrix.sv =====
// Builds R = Rz*Ry*Rx in Q2.30 from the CORDIC sines and cosines, two stages.
// Depends on ezr_pkg.
`timescale 1ns / 1ps
module ezr_matrix
	import ezr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_rdy,
	input  cell_t up,
	output logic  dn_valid,
	input  logic  dn_rdy,
	output mat_t  dn
);

	logic signed [TRIG_W-1:0] cs [3];
	logic signed [TRIG_W-1:0] sn [3];
	logic v_s1, v_s2, ld1, ld2;
	logic signed [TRIG_W-1:0] sa_s1, ca_s1, sb_s1, ccsb_s1, scsb_s1;
	logic signed [TRIG_W-1:0] m0_s1, m3_s1, m7_s1, m8_s1;
	logic signed [TRIG_W-1:0] scca_s1, scsa_s1, ccca_s1, ccsa_s1;
	coord_t [2:0] p_s1;
	mat_t nxt, m_s2;

	// fold correction: negate both when the angle was shifted by pi
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cs[k] = up.flip[k] ? TRIG_W'(-$signed(up.rot[k].x)) : TRIG_W'(up.rot[k].x);
			sn[k] = up.flip[k] ? TRIG_W'(-$signed(up.rot[k].y)) : TRIG_W'(up.rot[k].y);
		end
	end

	assign ld2 = !v_s2 || dn_rdy;
	assign ld1 = !v_s1 || ld2;
	assign up_rdy = ld1;
	assign dn_valid = v_s2;
	assign dn = m_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= up_valid;
			if (ld2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && up_valid) begin
			sa_s1 <= sn[0];
			ca_s1 <= cs[0];
			sb_s1 <= sn[1];
			ccsb_s1 <= qmul(cs[2], sn[1]);
			scsb_s1 <= qmul(sn[2], sn[1]);
			m0_s1 <= qmul(cs[2], cs[1]);
			m3_s1 <= qmul(sn[2], cs[1]);
			m7_s1 <= qmul(cs[1], sn[0]);
			m8_s1 <= qmul(cs[1], cs[0]);
			scca_s1 <= qmul(sn[2], cs[0]);
			scsa_s1 <= qmul(sn[2], sn[0]);
			ccca_s1 <= qmul(cs[2], cs[0]);
			ccsa_s1 <= qmul(cs[2], sn[0]);
			p_s1 <= up.p;
		end
	end

	always_comb begin
		nxt.p = p_s1;
		nxt.r[0] = MAT_W'(m0_s1);
		nxt.r[1] = MAT_W'(qmul(ccsb_s1, sa_s1)) - MAT_W'(scca_s1);
		nxt.r[2] = MAT_W'(qmul(ccsb_s1, ca_s1)) + MAT_W'(scsa_s1);
		nxt.r[3] = MAT_W'(m3_s1);
		nxt.r[4] = MAT_W'(qmul(scsb_s1, sa_s1)) + MAT_W'(ccca_s1);
		nxt.r[5] = MAT_W'(qmul(scsb_s1, ca_s1)) - MAT_W'(ccsa_s1);
		nxt.r[6] = -MAT_W'(sb_s1);
		nxt.r[7] = MAT_W'(m7_s1);
		nxt.r[8] = MAT_W'(m8_s1);
	end

	always_ff @(posedge clk) begin
		if (ld2 && v_s1) begin
			m_s2 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/ezr_dot.sv =====
// Matrix times point: split products, row sums, then round, shift and saturate.
// Depends on ezr_pkg.
`timescale 1ns / 1ps
module ezr_dot
	import ezr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_rdy,
	input  mat_t up,
	output logic dn_valid,
	input  logic dn_stall,
	output out_t dn
);

	localparam int LO_W = COORD_W / 2;
	localparam int HI_W = COORD_W - LO_W;
	localparam int PH_W = MAT_W + HI_W;
	localparam int PL_W = MAT_W + LO_W + 1;
	localparam int SA_W = PH_W + 2;
	localparam int SB_W = PL_W + 3;
	localparam int TW = SA_W + LO_W + 1;
	localparam logic signed [TW-1:0] MAXC = (TW'(1) <<< (COORD_W - 1)) - TW'(1);
	localparam logic signed [TW-1:0] MINC = -MAXC - TW'(1);

	logic v_s1, v_s2, v_s3, ld1, ld2, ld3;
	logic signed [PH_W-1:0] ph_s1 [3][3];
	logic signed [PL_W-1:0] pl_s1 [3][3];
	logic signed [SA_W-1:0] sa_s2 [3];
	logic signed [SB_W-1:0] sb_s2 [3];
	logic signed [COORD_W-1:0] res [3];
	out_t o_s3;

	assign ld3 = !v_s3 || !dn_stall;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign up_rdy = ld1;
	assign dn_valid = v_s3;
	assign dn = o_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= up_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
		end
	end

	// point split into a signed high half and an unsigned low half
	always_ff @(posedge clk) begin
		if (ld1 && up_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					ph_s1[i][j] <= $signed(up.r[i*3+j]) *
						$signed(up.p[2-j][COORD_W-1:LO_W]);
					pl_s1[i][j] <= $signed(up.r[i*3+j]) *
						$signed({1'b0, up.p[2-j][LO_W-1:0]});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				sa_s2[i] <= SA_W'(ph_s1[i][0]) + SA_W'(ph_s1[i][1]) + SA_W'(ph_s1[i][2]);
				sb_s2[i] <= SB_W'(pl_s1[i][0]) + SB_W'(pl_s1[i][1]) + SB_W'(pl_s1[i][2])
					+ SB_W'(Q_HALF);
			end
		end
	end

	always_comb begin
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] v;
		for (int i = 0; i < 3; i++) begin
			t = (TW'(sa_s2[i]) <<< LO_W) + TW'(sb_s2[i]);
			v = t >>> 30;
			if (v > MAXC) v = MAXC;
			else if (v < MINC) v = MINC;
			res[i] = COORD_W'(v);
		end
	end

	always_ff @(posedge clk) begin
		if (ld3 && v_s2) begin
			o_s3.out_x <= res[0];
			o_s3.out_y <= res[1];
			o_s3.out_z <= res[2];
		end
	end

endmodule

// ===== hw/rtl/euler_zyx_point_rotation_top.sv =====
// Rotates a Q16.16 point by roll, pitch and yaw (R = Rz*Ry*Rx). Takes one point per
// clock while dst_stall is low. The path is a fold register, one CORDIC cell per stage,
// two matrix stages and three dot-product stages ending in the output register.
// Every stage holds while the next is full, so bubbles close up under dst_stall.
// Depends on ezr_pkg, ezr_cell, ezr_matrix and ezr_dot.
`timescale 1ns / 1ps
module euler_zyx_point_rotation_top
	import ezr_pkg::*;
#(
	parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_stall,
	input  in_t  src_data,
	output logic dst_valid,
	input  logic dst_stall,
	output out_t dst_data
);

	cell_t chain [TRIG_STAGES+1];
	logic  vld [TRIG_STAGES+1];
	logic  rdy [TRIG_STAGES+1];
	logic  v_s0, ld0;
	cell_t f_s0, fold;
	logic signed [ANGLE_W-1:0] ang [3];
	logic  mat_valid, mat_rdy;
	mat_t  mat;
	logic  dot_rdy;

	assign ang[0] = src_data.roll_angle;
	assign ang[1] = src_data.pitch_angle;
	assign ang[2] = src_data.yaw_angle;

	// bring each angle into -pi/2..pi/2; the shift by pi negates sine and cosine later
	always_comb begin
		logic signed [ZW-1:0] z;
		fold.p[2] = src_data.in_x;
		fold.p[1] = src_data.in_y;
		fold.p[0] = src_data.in_z;
		for (int k = 0; k < 3; k++) begin
			z = ZW'(ang[k]) <<< ANG_SHIFT;
			fold.flip[k] = 1'b0;
			if (z > HALF_PI) begin
				z = z - PI_Q30;
				fold.flip[k] = 1'b1;
			end else if (z < -HALF_PI) begin
				z = z + PI_Q30;
				fold.flip[k] = 1'b1;
			end
			fold.rot[k].x = CORDIC_GAIN;
			fold.rot[k].y = '0;
			fold.rot[k].z = z;
		end
	end

	assign ld0 = !v_s0 || rdy[0];
	assign src_stall = !ld0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (ld0) begin
			v_s0 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld0 && src_valid) begin
			f_s0 <= fold;
		end
	end

	assign chain[0] = f_s0;
	assign vld[0] = v_s0;

	for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
		ezr_cell #(.STAGE(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[g]),
			.up_rdy   (rdy[g]),
			.up       (chain[g]),
			.dn_valid (vld[g+1]),
			.dn_rdy   (rdy[g+1]),
			.dn       (chain[g+1])
		);
	end

	assign rdy[TRIG_STAGES] = mat_rdy;

	ezr_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld[TRIG_STAGES]),
		.up_rdy   (mat_rdy),
		.up       (chain[TRIG_STAGES]),
		.dn_valid (mat_valid),
		.dn_rdy   (dot_rdy),
		.dn       (mat)
	);

	ezr_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mat_valid),
		.up_rdy   (dot_rdy),
		.up       (mat),
		.dn_valid (dst_valid),
		.dn_stall (dst_stall),
		.dn       (dst_data)
	);

`ifndef SYNTH
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s0 |-> ($signed(f_s0.rot[0].z) <= HALF_PI && $signed(f_s0.rot[0].z) >= -HALF_PI
			&& $signed(f_s0.rot[1].z) <= HALF_PI && $signed(f_s0.rot[1].z) >= -HALF_PI
			&& $signed(f_s0.rot[2].z) <= HALF_PI && $signed(f_s0.rot[2].z) >= -HALF_PI))
		else $error("fold left an angle outside -pi/2..pi/2");

	a_front_open: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s0 |-> !src_stall)
		else $error("input stalled with the fold register empty");

	a_residual: assert property (@(posedge clk) disable iff (!arst_n)
		vld[TRIG_STAGES] |->
			($signed(chain[TRIG_STAGES].rot[0].z) <= atan_q30(0)
			&& $signed(chain[TRIG_STAGES].rot[0].z) >= -atan_q30(0)
			&& $signed(chain[TRIG_STAGES].rot[2].z) <= atan_q30(0)
			&& $signed(chain[TRIG_STAGES].rot[2].z) >= -atan_q30(0)))
		else $error("CORDIC residual angle out of range");
`endif

endmodule
